// ===== rtl/core/id_latency_decade_histogram_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the latency histogram block
// Immediate-implication and next-cycle forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ID_LATENCY_DECADE_HISTOGRAM_DEFINES_SVH
`define ID_LATENCY_DECADE_HISTOGRAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IDLDH_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IDLDH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/idldh_pkg.sv =====
// ---------------------------------------------------------------------------
// idldh_pkg
// Types, sizes and the decade classifier shared by the histogram block.
// ---------------------------------------------------------------------------
package idldh_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int NUM_BUCKETS = 6;
    localparam int BUCKET_W    = 3;

    localparam logic [63:0] NS_PER_US = 64'd1000;
    localparam logic [63:0] LIM_1US   = NS_PER_US;
    localparam logic [63:0] LIM_10US  = NS_PER_US * 64'd10;
    localparam logic [63:0] LIM_100US = NS_PER_US * 64'd100;
    localparam logic [63:0] LIM_1MS   = NS_PER_US * 64'd1000;
    localparam logic [63:0] LIM_10MS  = NS_PER_US * 64'd10000;

    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] requester_id;
        logic [63:0] timestamp_ns;
    } in_item_t;

    typedef struct packed {
        logic                start_stored;
        logic                end_matched;
        logic [BUCKET_W-1:0] bucket_index;
        logic [63:0]         bucket_total;
        logic [63:0]         attempt_total;
        logic [63:0]         completion_total;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] owner;
        logic [63:0] start_time;
    } slot_entry_t;

    typedef struct packed {
        logic        go;
        logic [63:0] id;
    } srch_req_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        slot_entry_t       entry;
    } slot_wr_t;

    typedef struct packed {
        logic              init_done;
        logic              done;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [63:0]       hit_time;
        logic              free_ok;
        logic [SLOT_W-1:0] free_slot;
    } srch_res_t;

    typedef enum logic [1:0] {
        TBL_CLEAR,
        TBL_IDLE,
        TBL_SCAN
    } tbl_state_t;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_SCAN,
        TOP_ELAPSE,
        TOP_CLASSIFY,
        TOP_COMMIT,
        TOP_DONE
    } top_state_t;

    // Elapsed nanoseconds to decade bucket; thresholds are whole microseconds.
    function automatic logic [BUCKET_W-1:0] decade_of(input logic [63:0] elapsed);
        logic [BUCKET_W-1:0] b;
        if (elapsed < LIM_1US)        b = BUCKET_W'(0);
        else if (elapsed < LIM_10US)  b = BUCKET_W'(1);
        else if (elapsed < LIM_100US) b = BUCKET_W'(2);
        else if (elapsed < LIM_1MS)   b = BUCKET_W'(3);
        else if (elapsed < LIM_10MS)  b = BUCKET_W'(4);
        else                          b = BUCKET_W'(5);
        return b;
    endfunction

endpackage

// ===== rtl/core/id_latency_decade_histogram.sv =====
// Search: the slot search reads one table entry per cycle and stops at a matching id.
// Throughput: one item at a time; s_ready stays low until the result is loaded.
// Reset: synchronous, active low; afterwards a clearing pass over all TABLE_SLOTS
//   entries (1024) empties the slot table while s_ready stays low.
// ---------------------------------------------------------------------------
// id_latency_decade_histogram
// Pairs start and end events by id and counts elapsed times in six decades.
// ---------------------------------------------------------------------------
module id_latency_decade_histogram
    import idldh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    top_state_t          state_reg, state_next;
    in_item_t            item_reg, item_next;
    logic [63:0]         elapsed_reg, elapsed_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [63:0]         bucket_cnt_reg [NUM_BUCKETS];
    logic [63:0]         bucket_cnt_next [NUM_BUCKETS];
    logic [63:0]         attempts_reg, attempts_next;
    logic [63:0]         completions_reg, completions_next;
    out_item_t           result_reg, result_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    srch_req_t req;
    slot_wr_t  wr;
    srch_res_t res;
    logic [63:0] bucket_sum;

    idldh_slot_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .wr      (wr),
        .res     (res)
    );

    assign s_ready    = (state_reg == TOP_IDLE) && res.init_done;
    assign bucket_sum = bucket_cnt_reg[bucket_reg] + 64'd1;

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        elapsed_next     = elapsed_reg;
        bucket_next      = bucket_reg;
        bucket_cnt_next  = bucket_cnt_reg;
        attempts_next    = attempts_reg;
        completions_next = completions_reg;
        result_next      = result_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        req.go           = 1'b0;
        req.id           = s_data.requester_id;
        wr               = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            TOP_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next  = s_data;
                    req.go     = 1'b1;
                    state_next = TOP_SCAN;
                end
            end
            TOP_SCAN: begin
                if (res.done) begin
                    if (item_reg.operation == OP_END && res.hit) begin
                        state_next = TOP_ELAPSE;
                    end else begin
                        state_next = TOP_COMMIT;
                    end
                end
            end
            TOP_ELAPSE: begin
                // wraps modulo 2^64 when time runs backwards
                elapsed_next = item_reg.timestamp_ns - res.hit_time;
                state_next   = TOP_CLASSIFY;
            end
            TOP_CLASSIFY: begin
                bucket_next = decade_of(elapsed_reg);
                state_next  = TOP_COMMIT;
            end
            TOP_COMMIT: begin
                result_next = '0;
                if (item_reg.operation == OP_START) begin
                    attempts_next               = attempts_reg + 64'd1;
                    wr.en                       = res.hit || res.free_ok;
                    wr.slot                     = res.hit ? res.hit_slot : res.free_slot;
                    wr.entry.valid              = 1'b1;
                    wr.entry.owner              = item_reg.requester_id;
                    wr.entry.start_time         = item_reg.timestamp_ns;
                    result_next.start_stored    = res.hit || res.free_ok;
                    result_next.attempt_total   = attempts_reg + 64'd1;
                    result_next.completion_total = completions_reg;
                end else if (res.hit) begin
                    // free the slot and bump the bucket
                    wr.en                        = 1'b1;
                    wr.slot                      = res.hit_slot;
                    bucket_cnt_next[bucket_reg]  = bucket_sum;
                    completions_next             = completions_reg + 64'd1;
                    result_next.end_matched      = 1'b1;
                    result_next.bucket_index     = bucket_reg;
                    result_next.bucket_total     = bucket_sum;
                    result_next.attempt_total    = attempts_reg;
                    result_next.completion_total = completions_reg + 64'd1;
                end else begin
                    result_next.attempt_total    = attempts_reg;
                    result_next.completion_total = completions_reg;
                end
                state_next = TOP_DONE;
            end
            TOP_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = TOP_IDLE;
                end
            end
            default: state_next = TOP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= TOP_IDLE;
            attempts_reg    <= '0;
            completions_reg <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                bucket_cnt_reg[i] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            attempts_reg    <= attempts_next;
            completions_reg <= completions_next;
            m_valid_reg     <= m_valid_next;
            bucket_cnt_reg  <= bucket_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        elapsed_reg <= elapsed_next;
        bucket_reg  <= bucket_next;
        result_reg  <= result_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/idldh_slot_table.sv =====
// ---------------------------------------------------------------------------
// idldh_slot_table
// Slot memory with a clearing pass after reset and a linear owner search
// that also finds the lowest free slot, one entry read per cycle.
// ---------------------------------------------------------------------------
module idldh_slot_table
    import idldh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  srch_req_t req,
    input  slot_wr_t  wr,
    output srch_res_t res
);

    slot_entry_t mem [TABLE_SLOTS];

    tbl_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [63:0]       id_reg, id_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0] rd_idx_reg;
    slot_entry_t       rd_data_reg;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [63:0]       hit_time_reg, hit_time_next;
    logic              free_ok_reg, free_ok_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    slot_entry_t       mem_wdata;
    logic [SLOT_W-1:0] rd_addr;
    logic              issue;

    assign rd_addr = cnt_reg[SLOT_W-1:0];
    assign issue   = (state_reg == TBL_SCAN) && (cnt_reg < CNT_W'(TABLE_SLOTS));

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        id_next        = id_reg;
        rd_vld_next    = 1'b0;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_time_next  = hit_time_reg;
        free_ok_next   = free_ok_reg;
        free_slot_next = free_slot_reg;
        mem_we         = wr.en;
        mem_waddr      = wr.slot;
        mem_wdata      = wr.entry;
        unique case (state_reg)
            TBL_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[SLOT_W-1:0];
                mem_wdata = '0;
                if (cnt_reg == CNT_W'(TABLE_SLOTS - 1)) begin
                    cnt_next   = '0;
                    state_next = TBL_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            TBL_IDLE: begin
                if (req.go) begin
                    id_next      = req.id;
                    cnt_next     = '0;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                    state_next   = TBL_SCAN;
                end
            end
            TBL_SCAN: begin
                // issue the next read while the previous entry is checked
                if (issue) begin
                    cnt_next    = cnt_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    if (rd_data_reg.valid && rd_data_reg.owner == id_reg) begin
                        hit_next      = 1'b1;
                        hit_slot_next = rd_idx_reg;
                        hit_time_next = rd_data_reg.start_time;
                        rd_vld_next   = 1'b0;
                        done_next     = 1'b1;
                        state_next    = TBL_IDLE;
                    end else begin
                        if (!rd_data_reg.valid && !free_ok_reg) begin
                            free_ok_next   = 1'b1;
                            free_slot_next = rd_idx_reg;
                        end
                        if (rd_idx_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                            rd_vld_next = 1'b0;
                            done_next   = 1'b1;
                            state_next  = TBL_IDLE;
                        end
                    end
                end
            end
            default: state_next = TBL_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TBL_CLEAR;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            done_reg    <= done_next;
            hit_reg     <= hit_next;
            free_ok_reg <= free_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg        <= id_next;
        hit_slot_reg  <= hit_slot_next;
        hit_time_reg  <= hit_time_next;
        free_slot_reg <= free_slot_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    assign res.init_done = (state_reg != TBL_CLEAR);
    assign res.done      = done_reg;
    assign res.hit       = hit_reg;
    assign res.hit_slot  = hit_slot_reg;
    assign res.hit_time  = hit_time_reg;
    assign res.free_ok   = free_ok_reg;
    assign res.free_slot = free_slot_reg;

endmodule

// ===== rtl/core/idldh_checker.sv =====
// ---------------------------------------------------------------------------
// idldh_checker
// Port-level checks on the histogram block, attached by bind.
// ---------------------------------------------------------------------------
`include "id_latency_decade_histogram_defines.svh"

module idldh_checker
    import idldh_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `IDLDH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result item changed while stalled")

    `IDLDH_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while an item is in work")

    `IDLDH_ASSERT_NOW(a_bucket_range, aclk, aresetn, m_valid && m_data.end_matched, m_data.bucket_index <= BUCKET_W'(NUM_BUCKETS - 1), "bucket index out of range")

    `IDLDH_ASSERT_NOW(a_no_match_zero, aclk, aresetn, m_valid && !m_data.end_matched, m_data.bucket_index == '0 && m_data.bucket_total == '0, "bucket fields set without a match")

    `IDLDH_ASSERT_NOW(a_excl_flags, aclk, aresetn, m_valid, !(m_data.start_stored && m_data.end_matched), "stored and matched both set")

endmodule

bind id_latency_decade_histogram idldh_checker u_idldh_checker (.*);

// ===== tb/id_latency_decade_histogram_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// id_latency_decade_histogram_tb
// Self-checking bench for the start/end latency histogram. A clocked driver
// feeds events from a queue and a clocked monitor predicts each accepted
// event with its own copy of the slot table and counters. Accepted results
// are then checked field by field in order. The stimulus covers directed
// decade boundaries, time running backwards, and random paired traffic with
// overwrites and stray ends under several idle mixes.
// ---------------------------------------------------------------------------
module id_latency_decade_histogram_tb
    import idldh_pkg::*;
();

    localparam int      POOL_IDS   = 16;
    localparam int      LONG_HOLD  = 3000;
    localparam longint  LIMIT_NS   = 80_000_000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    id_latency_decade_histogram dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expected results
    in_item_t  event_q[$];
    out_item_t result_q[$];
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_reqs      = 0;
    int        error_count    = 0;
    logic      in_fire        = 1'b0;

    // shadow of the block state
    logic        shadow_live  [TABLE_SLOTS];
    logic [63:0] shadow_owner [TABLE_SLOTS];
    logic [63:0] shadow_start [TABLE_SLOTS];
    logic [63:0] shadow_bucket[NUM_BUCKETS];
    logic [63:0] shadow_attempts   = '0;
    logic [63:0] shadow_completed  = '0;

    // generator bookkeeping
    logic [63:0] pool_id  [POOL_IDS];
    logic        pool_open[POOL_IDS];
    logic [63:0] pool_ts  [POOL_IDS];

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            shadow_live[i] = 1'b0;
        end
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            shadow_bucket[b] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [2:0] decade_bucket(input logic [63:0] dt);
        logic [63:0] us;
        us = dt / 64'd1000;
        if (us < 64'd1)          return 3'd0;
        else if (us < 64'd10)    return 3'd1;
        else if (us < 64'd100)   return 3'd2;
        else if (us < 64'd1000)  return 3'd3;
        else if (us < 64'd10000) return 3'd4;
        return 3'd5;
    endfunction

    task automatic predict_event(input in_item_t ev);
        out_item_t   r;
        int          slot;
        logic [2:0]  b;
        r = '0;
        slot = -1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot < 0 && shadow_live[i] && shadow_owner[i] == ev.requester_id) begin
                slot = i;
            end
        end
        if (ev.operation == OP_START) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot < 0 && !shadow_live[i]) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                shadow_live[slot]  = 1'b1;
                shadow_owner[slot] = ev.requester_id;
                shadow_start[slot] = ev.timestamp_ns;
                r.start_stored     = 1'b1;
            end
            shadow_attempts = shadow_attempts + 64'd1;
        end else if (slot >= 0) begin
            b = decade_bucket(ev.timestamp_ns - shadow_start[slot]);
            shadow_bucket[b]  = shadow_bucket[b] + 64'd1;
            shadow_completed  = shadow_completed + 64'd1;
            shadow_live[slot] = 1'b0;
            r.end_matched     = 1'b1;
            r.bucket_index    = b;
            r.bucket_total    = shadow_bucket[b];
        end
        r.attempt_total    = shadow_attempts;
        r.completion_total = shadow_completed;
        result_q.push_back(r);
    endtask

    // input driver: hold the offered item until it is taken
    always @(negedge aclk) begin
        if (!s_valid || in_fire) begin
            if (aresetn && event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= event_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and an occasional long hold-off
    int hold_served = 0;
    int hold_left   = 0;
    always @(negedge aclk) begin
        if (hold_reqs != hold_served) begin
            hold_left = LONG_HOLD;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: check results first, then predict the item accepted this edge
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch("result with nothing pending", m_data.attempt_total, '0);
            end else begin
                want = result_q.pop_front();
                if (m_data.start_stored !== want.start_stored)
                    report_mismatch("start_stored", 64'(m_data.start_stored),
                                    64'(want.start_stored));
                if (m_data.end_matched !== want.end_matched)
                    report_mismatch("end_matched", 64'(m_data.end_matched),
                                    64'(want.end_matched));
                if (m_data.bucket_index !== want.bucket_index)
                    report_mismatch("bucket_index", 64'(m_data.bucket_index),
                                    64'(want.bucket_index));
                if (m_data.bucket_total !== want.bucket_total)
                    report_mismatch("bucket_total", m_data.bucket_total, want.bucket_total);
                if (m_data.attempt_total !== want.attempt_total)
                    report_mismatch("attempt_total", m_data.attempt_total, want.attempt_total);
                if (m_data.completion_total !== want.completion_total)
                    report_mismatch("completion_total", m_data.completion_total,
                                    want.completion_total);
            end
        end
        if (aresetn && s_valid && s_ready) begin
            predict_event(s_data);
        end
        in_fire <= aresetn && s_valid && s_ready;
    end

    task automatic push_event(input logic op, input logic [63:0] id, input logic [63:0] ts);
        in_item_t ev;
        ev.operation    = op;
        ev.requester_id = id;
        ev.timestamp_ns = ts;
        event_q.push_back(ev);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_elapsed();
        logic [63:0] edges[12];
        edges = '{64'd0, 64'd999, 64'd1000, 64'd9999, 64'd10000, 64'd99999,
                  64'd100000, 64'd999999, 64'd1000000, 64'd9999999,
                  64'd10000000, '1};
        case ($urandom_range(7))
            0: return 64'($urandom_range(999));
            1: return 64'($urandom_range(9999, 1000));
            2: return 64'($urandom_range(99999, 10000));
            3: return 64'($urandom_range(999999, 100000));
            4: return 64'($urandom_range(9999999, 1000000));
            5: return 64'd10000000 + 64'($urandom);
            6: return edges[$urandom_range(11)];
            default: return rand64();
        endcase
    endfunction

    // wait for the queue to empty and every result to be taken
    task automatic drain();
        while (event_q.size() != 0 || s_valid || result_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // mostly start/end pairs over a small id pool, plus overwrites and stray ends
    task automatic gen_random(input int n);
        int r;
        int k;
        logic [63:0] ts;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            k = $urandom_range(POOL_IDS - 1);
            if (r < 70) begin
                if (pool_open[k]) begin
                    push_event(OP_END, pool_id[k], pool_ts[k] + pick_elapsed());
                    pool_open[k] = 1'b0;
                end else begin
                    ts = rand64();
                    push_event(OP_START, pool_id[k], ts);
                    pool_open[k] = 1'b1;
                    pool_ts[k]   = ts;
                end
            end else if (r < 80) begin
                ts = rand64();
                push_event(OP_START, pool_id[k], ts);
                pool_open[k] = 1'b1;
                pool_ts[k]   = ts;
            end else if (r < 90) begin
                push_event(OP_END, pool_id[k], rand64());
                pool_open[k] = 1'b0;
            end else begin
                push_event(OP_END, rand64(), rand64());
            end
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        gen_random(n);
        drain();
    endtask

    initial begin
        logic [63:0] base;
        logic [63:0] gaps[9];
        gaps = '{64'd1000, 64'd9999, 64'd10000, 64'd99999, 64'd100000,
                 64'd999999, 64'd1000000, 64'd9999999, 64'd10000000};
        for (int k = 0; k < POOL_IDS; k++) begin
            pool_id[k]   = rand64();
            pool_open[k] = 1'b0;
            pool_ts[k]   = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty-table end, overwrite, wrap, double end, boundaries
        push_event(OP_END,   64'd0, 64'd0);
        push_event(OP_START, '1, 64'd100);
        push_event(OP_START, '1, '1 - 64'd500);
        push_event(OP_END,   '1, ('1 - 64'd500) + 64'd999);
        push_event(OP_END,   '1, 64'd12345);
        for (int i = 0; i < 9; i++) begin
            base = rand64();
            push_event(OP_START, 64'd0, base);
            push_event(OP_END,   64'd0, base + gaps[i]);
        end
        // time going backwards
        push_event(OP_START, 64'd0, 64'd5000);
        push_event(OP_END,   64'd0, 64'd4999);
        drain();

        run_phase(0, 0, 140);
        run_phase(46, 0, 140);
        // long receiver hold-off while the sender keeps offering
        hold_reqs++;
        run_phase(0, 46, 140);
        run_phase(21, 21, 140);

        repeat (TABLE_SLOTS + 16) @(posedge aclk);
        if (error_count == 0 && result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/idldh_pkg.sv
rtl/core/idldh_slot_table.sv
rtl/core/id_latency_decade_histogram.sv
rtl/core/idldh_checker.sv
tb/id_latency_decade_histogram_tb.sv
